[design/mwm_pkg.sv]
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared types and constants of the mecanum wheel mixer: command and result
// transaction layouts, internal widths, direction codes and divider lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

    // Width of one velocity or rotation command.
    localparam int CMD_BITS = 8;
    // Width of a wheel duty and of the maximum speed register.
    localparam int DUTY_W   = 10;
    // A mixed speed is the sum of three commands.
    localparam int SUM_W    = CMD_BITS + 2;
    // Magnitude of a mixed speed, at most three times the largest command.
    localparam int MAG_W    = CMD_BITS + 1;
    // Dividend of the scaling division: magnitude times maximum speed.
    localparam int NUM_W    = MAG_W + DUTY_W;
    // Common width for comparing a magnitude with the maximum speed.
    localparam int CMP_W    = (MAG_W > DUTY_W) ? MAG_W : DUTY_W;

    localparam logic [DUTY_W-1:0] MAX_SPEED_RESET = DUTY_W'(100);

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    typedef struct packed {
        logic signed [CMD_BITS-1:0] vel_x;
        logic signed [CMD_BITS-1:0] vel_y;
        logic signed [CMD_BITS-1:0] turn_rate;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        front_left_dir;
        logic [DUTY_W-1:0] front_left_duty;
        logic [1:0]        front_right_dir;
        logic [DUTY_W-1:0] front_right_duty;
        logic [1:0]        back_left_dir;
        logic [DUTY_W-1:0] back_left_duty;
        logic [1:0]        back_right_dir;
        logic [DUTY_W-1:0] back_right_duty;
    } result_t;

    // One wheel inside the divider: partial remainder, quotient so far, and
    // whether the final wheel speed is negative.
    typedef struct packed {
        logic [NUM_W-1:0]  rem;
        logic [DUTY_W-1:0] quo;
        logic              rev;
    } div_lane_t;

    // Everything one divider stage hands to the next.
    typedef struct packed {
        div_lane_t [3:0]  lane;
        logic [MAG_W-1:0] den;
    } div_bus_t;

    function automatic logic [1:0] wheel_dir(input logic [DUTY_W-1:0] duty,
                                             input logic rev);
        logic [1:0] dir;
        if (duty == '0) begin
            dir = DIR_STOP;
        end else if (rev) begin
            dir = DIR_REV;
        end else begin
            dir = DIR_FWD;
        end
        return dir;
    endfunction

endpackage

`default_nettype wire

[design/mwm_div_step.sv]
// ----------------------------------------------------------------------------
// mwm_div_step
// One registered step of the restoring divider: resolves a single quotient
// bit for all four wheels against the shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_div_step
    import mwm_pkg::*;
#(
    parameter int BIT = 0
) (
    input  wire logic     aclk,
    input  wire logic     load_en,
    input  wire div_bus_t bus_i,
    output div_bus_t      bus_o
);

    localparam int SH = BIT;

    div_bus_t          bus_reg;
    div_bus_t          bus_next;
    logic [NUM_W-1:0]  sub_val;
    logic [NUM_W:0]    trial [4];

    // The shifted divisor fits because the shift is at most DUTY_W-1 and NUM_W is MAG_W + DUTY_W.
    assign sub_val = NUM_W'(bus_i.den) << SH;

    always_comb begin
        bus_next = bus_i;
        for (int k = 0; k < 4; k++) begin
            trial[k] = {1'b0, bus_i.lane[k].rem} - {1'b0, sub_val};
            if (!trial[k][NUM_W]) begin
                bus_next.lane[k].rem      = trial[k][NUM_W-1:0];
                bus_next.lane[k].quo[SH]  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            bus_reg <= bus_next;
        end
    end

    assign bus_o = bus_reg;

endmodule

`default_nettype wire

[design/mecanum_wheel_mixer_unit.sv]
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_unit
// Mixes a lateral, forward and rotation command into four mecanum wheel
// direction codes and PWM duties, scaled down to the configured maximum.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction enters on s_valid/s_ready with s_cmd; one result
// transaction with a direction and a duty for each wheel leaves on
// m_valid/m_ready with m_result. Every command gives exactly one result.
// The block is a pipeline of 15 register stages: mixing, magnitudes,
// largest magnitude and limit check, multiply by the speed cap, ten restoring
// divider steps (one quotient bit each) and an output register. A new
// command can be taken on every cycle while m_ready stays high, so
// the sustained rate is one transaction per clock. Each stage moves
// forward when it is empty or the stage after it moves, so a stalled
// receiver only holds the stages that are full; s_ready falls only when
// all 15 stages hold a transaction and m_ready is low. Nothing is lost
// or repeated.
// The speed cap is written through cfg_we/cfg_wdata and is meant to change
// only while no transaction is in flight. A synchronous reset (aresetn low)
// empties the pipeline and sets the speed cap to 100.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_mixer_unit
    import mwm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cmd_t              s_cmd,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output result_t                m_result,

    input  wire logic              cfg_we,
    input  wire logic [DUTY_W-1:0] cfg_wdata
);

    // Stage numbering: 0 mix, 1 magnitude, 2 limit check, 3 multiply,
    // then the divider steps and finally the output register.
    localparam int ST_MIX  = 0;
    localparam int ST_MAG  = 1;
    localparam int ST_LIM  = 2;
    localparam int ST_MUL  = 3;
    localparam int ST_DIV0 = 4;
    localparam int ST_OUT  = ST_DIV0 + DUTY_W;
    localparam int NSTG    = ST_OUT + 1;

    logic [DUTY_W-1:0] speed_cap_reg;

    logic [NSTG-1:0]   valid_reg;
    logic [NSTG-1:0]   valid_next;
    logic [NSTG-1:0]   stg_en;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_cap_reg <= MAX_SPEED_RESET;
        end else if (cfg_we) begin
            speed_cap_reg <= cfg_wdata;
        end
    end

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        stg_en[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !valid_reg[k] || stg_en[k+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (stg_en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (stg_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stg_en[ST_MIX];
    assign m_valid = valid_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Stage 0: the four wheel mixes, in the order LF, RF, LB, RB.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] vx_ext;
    logic signed [SUM_W-1:0] vy_ext;
    logic signed [SUM_W-1:0] w_ext;
    logic signed [SUM_W-1:0] sum_next [4];
    logic signed [SUM_W-1:0] sum_reg  [4];

    assign vx_ext = SUM_W'(s_cmd.vel_x);
    assign vy_ext = SUM_W'(s_cmd.vel_y);
    assign w_ext  = SUM_W'(s_cmd.turn_rate);

    assign sum_next[0] = vy_ext + vx_ext - w_ext;
    assign sum_next[1] = vy_ext - vx_ext + w_ext;
    assign sum_next[2] = vy_ext - vx_ext - w_ext;
    assign sum_next[3] = vy_ext + vx_ext + w_ext;

    always_ff @(posedge aclk) begin
        if (stg_en[ST_MIX]) begin
            sum_reg <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: magnitudes, final signs and the two pairwise maxima.
    // The left wheels are negated at the end, so their reverse flag is
    // set when the mix is positive.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mag_next  [4];
    logic [MAG_W-1:0] mag1_reg  [4];
    logic [3:0]       rev_next;
    logic [3:0]       rev1_reg;
    logic [MAG_W-1:0] max01_reg;
    logic [MAG_W-1:0] max23_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag_next[k] = sum_reg[k][SUM_W-1] ? MAG_W'(-sum_reg[k])
                                              : MAG_W'(sum_reg[k]);
        end
        rev_next[0] = !sum_reg[0][SUM_W-1];
        rev_next[1] =  sum_reg[1][SUM_W-1];
        rev_next[2] = !sum_reg[2][SUM_W-1];
        rev_next[3] =  sum_reg[3][SUM_W-1];
    end

    always_ff @(posedge aclk) begin
        if (stg_en[ST_MAG]) begin
            mag1_reg  <= mag_next;
            rev1_reg  <= rev_next;
            max01_reg <= (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
            max23_reg <= (mag_next[2] > mag_next[3]) ? mag_next[2] : mag_next[3];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: largest magnitude and whether scaling is needed.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] largest_next;
    logic [MAG_W-1:0] largest_reg;
    logic [MAG_W-1:0] mag2_reg [4];
    logic [3:0]       rev2_reg;
    logic             scale_reg;

    assign largest_next = (max01_reg > max23_reg) ? max01_reg : max23_reg;

    always_ff @(posedge aclk) begin
        if (stg_en[ST_LIM]) begin
            mag2_reg    <= mag1_reg;
            rev2_reg    <= rev1_reg;
            largest_reg <= largest_next;
            scale_reg   <= CMP_W'(largest_next) > CMP_W'(speed_cap_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: build the dividend and divisor. When scaling, the quotient
    // is mag * speed cap / largest. Otherwise dividing the magnitude by one
    // passes it through unchanged, since it is already at or below the cap.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] mag_wide [4];
    logic [NUM_W-1:0] lim_wide;
    logic [NUM_W-1:0] prod     [4];
    div_bus_t         div0_next;
    div_bus_t         div0_reg;

    assign lim_wide = NUM_W'(speed_cap_reg);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag_wide[k] = NUM_W'(mag2_reg[k]);
            prod[k]     = mag_wide[k] * lim_wide;
            div0_next.lane[k].rem = scale_reg ? prod[k] : mag_wide[k];
            div0_next.lane[k].quo = '0;
            div0_next.lane[k].rev = rev2_reg[k];
        end
        div0_next.den = scale_reg ? largest_reg : MAG_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[ST_MUL]) begin
            div0_reg <= div0_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, most significant first.
    // ------------------------------------------------------------------
    div_bus_t div_bus [DUTY_W+1];

    assign div_bus[0] = div0_reg;

    for (genvar i = 0; i < DUTY_W; i++) begin : g_div
        mwm_div_step #(
            .BIT (DUTY_W - 1 - i)
        ) u_step (
            .aclk    (aclk),
            .load_en (stg_en[ST_DIV0 + i]),
            .bus_i   (div_bus[i]),
            .bus_o   (div_bus[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register: direction codes and duties.
    // ------------------------------------------------------------------
    div_bus_t div_last;
    result_t  result_next;
    result_t  m_result_reg;

    assign div_last = div_bus[DUTY_W];

    always_comb begin
        result_next.front_left_duty  = div_last.lane[0].quo;
        result_next.front_left_dir   = wheel_dir(div_last.lane[0].quo, div_last.lane[0].rev);
        result_next.front_right_duty = div_last.lane[1].quo;
        result_next.front_right_dir  = wheel_dir(div_last.lane[1].quo, div_last.lane[1].rev);
        result_next.back_left_duty   = div_last.lane[2].quo;
        result_next.back_left_dir    = wheel_dir(div_last.lane[2].quo, div_last.lane[2].rev);
        result_next.back_right_duty  = div_last.lane[3].quo;
        result_next.back_right_dir   = wheel_dir(div_last.lane[3].quo, div_last.lane[3].rev);
    end

    always_ff @(posedge aclk) begin
        if (stg_en[ST_OUT]) begin
            m_result_reg <= result_next;
        end
    end

    assign m_result = m_result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The input side only stalls when every stage is occupied.
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg && !m_ready))
        else $error("s_ready low while a pipeline stage is empty");

    // After the last divider step every remainder is below the divisor,
    // which shows that the quotient did not overflow its duty width.
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[ST_OUT-1] |->
            (div_last.lane[0].rem < NUM_W'(div_last.den)) &&
            (div_last.lane[1].rem < NUM_W'(div_last.den)) &&
            (div_last.lane[2].rem < NUM_W'(div_last.den)) &&
            (div_last.lane[3].rem < NUM_W'(div_last.den)))
        else $error("divider remainder not below divisor");

    // A wheel reports stop exactly when its duty is zero.
    a_stop_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            ((m_result.front_left_dir  == DIR_STOP) == (m_result.front_left_duty  == '0)) &&
            ((m_result.front_right_dir == DIR_STOP) == (m_result.front_right_duty == '0)) &&
            ((m_result.back_left_dir   == DIR_STOP) == (m_result.back_left_duty   == '0)) &&
            ((m_result.back_right_dir  == DIR_STOP) == (m_result.back_right_duty  == '0)))
        else $error("direction code disagrees with duty");

    // A stage that moves on while the next one is held would overwrite it.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_OUT] && !m_ready) |=> $stable(m_result))
        else $error("stalled result changed");

endmodule

`default_nettype wire

[verif/wheel_mix_checker.sv]
// ----------------------------------------------------------------------------
// wheel_mix_checker
// Watches the command and result channels of the mecanum wheel mixer, works
// out the four wheel directions and duties of every accepted command and
// compares them, in order, with the results that the block delivers.
// ----------------------------------------------------------------------------

module wheel_mix_checker
    import mwm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    input  logic              s_ready,
    input  cmd_t              s_cmd,

    input  logic              m_valid,
    input  logic              m_ready,
    input  result_t           m_result,

    input  logic              cfg_we,
    input  logic [DUTY_W-1:0] cfg_wdata,

    output int                pending,
    output int                fail_count,
    output int                checked_count
);

    logic [DUTY_W-1:0] speed_limit = MAX_SPEED_RESET;
    result_t           expected_wheels_q[$];
    int                mismatches = 0;
    int                checked    = 0;

    // Direction code and duty of one wheel from its signed final speed.
    function automatic logic [DUTY_W+1:0] wheel_drive(input int speed);
        logic [1:0]        dir;
        logic [DUTY_W-1:0] duty;
        if (speed > 0) begin
            dir  = DIR_FWD;
            duty = DUTY_W'(speed);
        end else if (speed < 0) begin
            dir  = DIR_REV;
            duty = DUTY_W'(-speed);
        end else begin
            dir  = DIR_STOP;
            duty = '0;
        end
        return {dir, duty};
    endfunction

    // Mixes one command into four wheel speeds, scales them down when the
    // largest magnitude is above the limit, and negates the left wheels.
    function automatic result_t predict_wheels(input cmd_t cmd,
                                               input logic [DUTY_W-1:0] limit);
        int      vx;
        int      vy;
        int      rot;
        int      lim;
        int      largest;
        int      spd[4];
        result_t res;
        vx  = cmd.vel_x;
        vy  = cmd.vel_y;
        rot = cmd.turn_rate;
        lim = int'(limit);
        spd[0] = vy + vx - rot;
        spd[1] = vy - vx + rot;
        spd[2] = vy - vx - rot;
        spd[3] = vy + vx + rot;
        largest = 0;
        for (int k = 0; k < 4; k++) begin
            if ((spd[k] < 0 ? -spd[k] : spd[k]) > largest) begin
                largest = spd[k] < 0 ? -spd[k] : spd[k];
            end
        end
        // Integer division in SystemVerilog truncates toward zero as well.
        if (largest > lim) begin
            for (int k = 0; k < 4; k++) begin
                spd[k] = (spd[k] * lim) / largest;
            end
        end
        {res.front_left_dir, res.front_left_duty}   = wheel_drive(-spd[0]);
        {res.front_right_dir, res.front_right_duty} = wheel_drive(spd[1]);
        {res.back_left_dir, res.back_left_duty}     = wheel_drive(-spd[2]);
        {res.back_right_dir, res.back_right_duty}   = wheel_drive(spd[3]);
        return res;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            speed_limit = MAX_SPEED_RESET;
            expected_wheels_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                expected_wheels_q.push_back(predict_wheels(s_cmd, speed_limit));
            end
            if (m_valid && m_ready) begin
                if (expected_wheels_q.size() == 0) begin
                    $error("result transaction arrived with no command outstanding");
                    mismatches++;
                end else begin
                    want = expected_wheels_q.pop_front();
                    compare_field("front_left_dir", want.front_left_dir,
                                  m_result.front_left_dir);
                    compare_field("front_left_duty", want.front_left_duty,
                                  m_result.front_left_duty);
                    compare_field("front_right_dir", want.front_right_dir,
                                  m_result.front_right_dir);
                    compare_field("front_right_duty", want.front_right_duty,
                                  m_result.front_right_duty);
                    compare_field("back_left_dir", want.back_left_dir,
                                  m_result.back_left_dir);
                    compare_field("back_left_duty", want.back_left_duty,
                                  m_result.back_left_duty);
                    compare_field("back_right_dir", want.back_right_dir,
                                  m_result.back_right_dir);
                    compare_field("back_right_duty", want.back_right_duty,
                                  m_result.back_right_duty);
                    checked++;
                end
            end
            if (cfg_we) begin
                speed_limit = cfg_wdata;
            end
        end
        pending       <= expected_wheels_q.size();
        fail_count    <= mismatches;
        checked_count <= checked;
    end

endmodule

[verif/mecanum_wheel_mixer_unit_tb.sv]
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_unit_tb
// Drives commands into the mecanum wheel mixer under a series of maximum
// speed settings, with random idle gaps on both channels, a long receiver
// stall and full drains, while a separate checker predicts every result.
// ----------------------------------------------------------------------------

module mecanum_wheel_mixer_unit_tb
    import mwm_pkg::*;
();

    // Hard stop for the whole run, far above the slowest legal run.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Length of the one deliberate receiver stall. It is much longer than
    // the 15-stage pipeline, so the block fills up and drops s_ready.
    localparam int LONG_HOLD   = 120;
    // Commands offered back to back while that stall is in progress.
    localparam int BURST_ITEMS = 60;
    // Random commands per maximum speed setting.
    localparam int PHASE_ITEMS = 215;
    // Cycles watched after the last result, a little beyond the latency.
    localparam int DRAIN_TAIL  = 20;
    localparam int NUM_PHASES  = 8;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    cmd_t              s_cmd     = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    result_t           m_result;
    logic              cfg_we    = 1'b0;
    logic [DUTY_W-1:0] cfg_wdata = '0;

    // Set by the stimulus to switch off receiver idling for a phase.
    logic              rx_steady     = 1'b0;
    // Each increment asks the receiver for one long stall.
    int                hold_requests = 0;

    int                pending;
    int                fail_count;
    int                checked_count;
    int                cmds_sent     = 0;
    int                settings_used = 1;

    mecanum_wheel_mixer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    wheel_mix_checker mix_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .pending       (pending),
        .fail_count    (fail_count),
        .checked_count (checked_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Reset is held at the start and never asserted again.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // The watchdog counts cycles and gives up at the limit. A healthy run
    // ends through the stimulus process long before this point.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Run stopped after %0d cycles without finishing.", cycles);
        $display("FAILURE");
        $finish;
    end

    // Idle gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit steady);
        int roll;
        if (steady) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic cmd_t make_cmd(input int vx, input int vy, input int rot);
        cmd_t c;
        c.vel_x     = CMD_BITS'(vx);
        c.vel_y     = CMD_BITS'(vy);
        c.turn_rate = CMD_BITS'(rot);
        return c;
    endfunction

    // One of the values at or next to the ends of the command range, or at or next to zero.
    function automatic int edge_value();
        int pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0: return -(1 << (CMD_BITS - 1));
            1: return (1 << (CMD_BITS - 1)) - 1;
            2: return -1;
            3: return 1;
            4: return 0;
            default: return -(1 << (CMD_BITS - 1)) + 1;
        endcase
    endfunction

    // Most commands are uniform over the whole field, so every bit toggles.
    // Some are small, so that generous limits leave them unscaled, and some
    // sit at the ends of the range, where the mix is largest.
    function automatic cmd_t random_cmd();
        int   pick;
        cmd_t c;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            c.vel_x     = CMD_BITS'($urandom);
            c.vel_y     = CMD_BITS'($urandom);
            c.turn_rate = CMD_BITS'($urandom);
        end else if (pick < 8) begin
            c = make_cmd(int'($urandom_range(0, 40)) - 20,
                         int'($urandom_range(0, 40)) - 20,
                         int'($urandom_range(0, 40)) - 20);
        end else begin
            c = make_cmd(edge_value(), edge_value(), edge_value());
        end
        return c;
    endfunction

    // The receiver runs in its own process. It idles at random, stays ready
    // throughout when rx_steady is set, and serves each long stall request
    // by counting the stall out itself while the sender keeps offering.
    initial begin : receiver
        int gap;
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_requests != holds_done) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                gap = pick_gap(rx_steady);
                if (gap == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // Offers one command and returns at the edge where the transaction is
    // accepted. s_valid stays high, so a following command can go out at
    // once without dropping valid in between.
    task automatic send_cmd(input cmd_t c);
        s_valid <= 1'b1;
        s_cmd   <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cmds_sent++;
    endtask

    // Optional idle stretch on the command side after an accepted command.
    task automatic pace_tx(input bit steady);
        int gap;
        gap = pick_gap(steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering and waits until every predicted result has come back.
    // The checker's count is registered, so the task waits for an edge first.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    // One-cycle register write; only used while the pipeline is empty.
    task automatic write_speed_cap(input logic [DUTY_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        cmd_t              directed_q[$];
        logic [DUTY_W-1:0] plan[NUM_PHASES];
        bit                steady;

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // Directed commands under the reset limit of 100: the idle command,
        // each input alone at both ends, everything at the ends together
        // (largest mix of three full commands), a mix exactly at the limit
        // and just above it, a wheel that stops while others turn, and a
        // negative mix whose scaled value must truncate toward zero.
        directed_q.push_back(make_cmd(0, 0, 0));
        directed_q.push_back(make_cmd(127, 0, 0));
        directed_q.push_back(make_cmd(-128, 0, 0));
        directed_q.push_back(make_cmd(0, 127, 0));
        directed_q.push_back(make_cmd(0, -128, 0));
        directed_q.push_back(make_cmd(0, 0, 127));
        directed_q.push_back(make_cmd(0, 0, -128));
        directed_q.push_back(make_cmd(127, 127, 127));
        directed_q.push_back(make_cmd(-128, -128, -128));
        directed_q.push_back(make_cmd(127, -128, 127));
        directed_q.push_back(make_cmd(-128, 127, -128));
        directed_q.push_back(make_cmd(0, 100, 0));
        directed_q.push_back(make_cmd(0, 101, 0));
        directed_q.push_back(make_cmd(10, 10, 0));
        directed_q.push_back(make_cmd(0, 5, 5));
        directed_q.push_back(make_cmd(-2, -127, 0));
        directed_q.push_back(make_cmd(1, -1, 1));
        directed_q.push_back(make_cmd(-1, 0, 0));
        foreach (directed_q[i]) begin
            send_cmd(directed_q[i]);
            pace_tx(1'b0);
        end

        // Limit settings: the full range, the smallest legal limit, zero
        // (every wheel must stop), values around the largest possible mix,
        // two random ones, and back to the reset value.
        plan[0] = DUTY_W'(1023);
        plan[1] = DUTY_W'(1);
        plan[2] = DUTY_W'(0);
        plan[3] = DUTY_W'(383);
        plan[4] = DUTY_W'(384);
        plan[5] = DUTY_W'($urandom_range(1, 1023));
        plan[6] = DUTY_W'($urandom_range(2, 200));
        plan[7] = MAX_SPEED_RESET;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            write_speed_cap(plan[p]);
            // Two phases run with no idling at all on either side.
            steady = (p == 1) || (p == 5);
            rx_steady <= steady;

            if (p == 3) begin
                // Ask for the long receiver stall and keep offering commands
                // back to back through it, then pause until all have come out.
                hold_requests <= hold_requests + 1;
                repeat (BURST_ITEMS) send_cmd(random_cmd());
                wait_drained();
            end

            repeat (PHASE_ITEMS) begin
                send_cmd(random_cmd());
                pace_tx(steady);
            end
        end

        wait_drained();
        rx_steady <= 1'b0;
        // Watch a little longer for a stray result transaction.
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("Covered %0d commands across %0d speed cap settings, %0d results checked,",
                 cmds_sent, settings_used, checked_count);
        $display("with random idling, back-to-back bursts and one full pipeline stall.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
design/mwm_pkg.sv
design/mwm_div_step.sv
design/mecanum_wheel_mixer_unit.sv
verif/wheel_mix_checker.sv
verif/mecanum_wheel_mixer_unit_tb.sv
